@@ rtl/core/prrs_pkg.sv @@
package prrs_pkg;

  // Fixed field widths
  localparam int LVL_W   = 4;
  localparam int REM_W   = 12;
  localparam int Q_W     = 8;
  localparam int TIME_W  = 18;
  localparam int SUM_W   = 24;
  localparam int TIDX_W  = 5;
  localparam int TCNT_W  = 6;
  localparam int IN_DW   = 16;
  localparam int OUT_DW  = 88;

  // Default configuration
  localparam int DEF_MAX_TASKS    = 32;
  localparam int DEF_TOP_LEVEL    = 10;
  localparam int DEF_BOTTOM_LEVEL = 1;
  localparam logic [Q_W-1:0] QUANTUM_RST = 8'd10;

  // Saturation limits
  localparam logic [TIME_W-1:0] TIME_MAX = 18'h3FFFF;
  localparam logic [SUM_W-1:0]  SUM_MAX  = 24'hFFFFFF;

  // Input word kinds (tuser)
  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_STEP = 1'b1
  } prrs_op_t;

  // Result word kinds (tuser)
  typedef enum logic [1:0] {
    ST_ADD_OK  = 2'd0,
    ST_SLICE   = 2'd1,
    ST_NONE    = 2'd2,
    ST_ADD_REJ = 2'd3
  } prrs_status_t;

  // Write command broadcast to the cells
  typedef struct packed {
    logic             en;
    logic             set_level;
    logic [LVL_W-1:0] level;
    logic [REM_W-1:0] rem;
    logic             live;
  } prrs_cmd_t;

endpackage

@@ rtl/core/prrs_cell.sv @@
module prrs_cell
  import prrs_pkg::*;
#(
  parameter int IDX_W = 5,
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  // step context
  input  logic [LVL_W-1:0] serving,
  input  logic [IDX_W-1:0] ptr,
  // entry write
  input  prrs_cmd_t        cmd,
  input  logic [IDX_W-1:0] cmd_idx,
  // search word from the previous cell
  input  logic             q_found_i,
  input  logic [LVL_W-1:0] q_lvl_i,
  input  logic [IDX_W-1:0] q_idx_i,
  input  logic [REM_W-1:0] q_rem_i,
  // search word to the next cell
  output logic             q_found_o,
  output logic [LVL_W-1:0] q_lvl_o,
  output logic [IDX_W-1:0] q_idx_o,
  output logic [REM_W-1:0] q_rem_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic             live_r;
  logic [LVL_W-1:0] level_r;
  logic [REM_W-1:0] rem_r;

  logic             q_found_r;
  logic [LVL_W-1:0] q_lvl_r;
  logic [IDX_W-1:0] q_idx_r;
  logic [REM_W-1:0] q_rem_r;

  logic cand;
  logic wrap_fix;
  logic take;

  // A live entry at or below the serving level replaces the running best:
  // higher level wins, first index wins on a tie, except that at the serving
  // level an entry at or past the rotation pointer beats one before it.
  always_comb begin
    cand     = live_r && (level_r <= serving);
    wrap_fix = (level_r == serving) && (q_lvl_i == serving) &&
               (q_idx_i < ptr) && (MY_IDX >= ptr);
    take     = cand && (!q_found_i || (level_r > q_lvl_i) || wrap_fix);
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else if (cmd.en && (cmd_idx == MY_IDX)) begin
      live_r <= cmd.live;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.en && (cmd_idx == MY_IDX)) begin
      rem_r <= cmd.rem;
      if (cmd.set_level) begin
        level_r <= cmd.level;
      end
    end
  end

  // Search word stage
  always_ff @(posedge clk) begin
    if (take) begin
      q_found_r <= 1'b1;
      q_lvl_r   <= level_r;
      q_idx_r   <= MY_IDX;
      q_rem_r   <= rem_r;
    end else begin
      q_found_r <= q_found_i;
      q_lvl_r   <= q_lvl_i;
      q_idx_r   <= q_idx_i;
      q_rem_r   <= q_rem_i;
    end
  end

  assign q_found_o = q_found_r;
  assign q_lvl_o   = q_lvl_r;
  assign q_idx_o   = q_idx_r;
  assign q_rem_o   = q_rem_r;

endmodule

@@ rtl/core/prrs_ctrl.sv @@
module prrs_ctrl
  import prrs_pkg::*;
#(
  parameter int MAX_TASKS    = DEF_MAX_TASKS,
  parameter int TOP_LEVEL    = DEF_TOP_LEVEL,
  parameter int BOTTOM_LEVEL = DEF_BOTTOM_LEVEL,
  parameter int IDX_W        = $clog2(MAX_TASKS),
  parameter int CNT_W        = $clog2(MAX_TASKS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic              in_tuser,
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,
  output logic [1:0]        out_tuser,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [Q_W-1:0]    cfg_wr_data,
  // cell chain
  output logic [LVL_W-1:0]  serving,
  output logic [IDX_W-1:0]  ptr,
  output prrs_cmd_t         cmd,
  output logic [IDX_W-1:0]  cmd_idx,
  input  logic              q_found,
  input  logic [LVL_W-1:0]  q_lvl,
  input  logic [IDX_W-1:0]  q_idx,
  input  logic [REM_W-1:0]  q_rem
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TASKS);
  localparam logic [LVL_W-1:0] TOP_LVL  = LVL_W'(TOP_LEVEL);
  localparam logic [LVL_W-1:0] BOT_LVL  = LVL_W'(BOTTOM_LEVEL);

  state_t            state_r;
  logic [IDX_W-1:0]  cnt_r;
  logic              op_r;
  logic [LVL_W-1:0]  pri_r;
  logic [REM_W-1:0]  burst_r;
  logic              res_found_r;
  logic [LVL_W-1:0]  res_lvl_r;
  logic [IDX_W-1:0]  res_idx_r;
  logic [REM_W-1:0]  res_rem_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  live_cnt_r;
  logic [LVL_W-1:0]  serving_r;
  logic [IDX_W-1:0]  ptr_r;
  logic [TIME_W-1:0] elapsed_r;
  logic [SUM_W-1:0]  tsum_r;
  logic              stepping_r;
  logic [Q_W-1:0]    quantum_r;
  logic              out_valid_r;
  logic [OUT_DW-1:0] out_tdata_r;
  logic [1:0]        out_tuser_r;

  logic              commit;
  logic              add_ok;
  logic [Q_W-1:0]    slice;
  logic [REM_W-1:0]  new_rem;
  logic              fin;
  logic [TIME_W:0]   el_sum;
  logic [TIME_W-1:0] el_sat;
  logic [SUM_W:0]    ts_sum;
  logic [SUM_W-1:0]  ts_sat;

  prrs_status_t      st_o;
  logic [TIDX_W-1:0] idx_o;
  logic [Q_W-1:0]    slice_o;
  logic              fin_o;
  logic [CNT_W-1:0]  count_nxt;
  logic [CNT_W-1:0]  live_cnt_nxt;
  logic [TIME_W-1:0] elapsed_nxt;
  logic [SUM_W-1:0]  tsum_nxt;
  logic [LVL_W-1:0]  serving_nxt;
  logic [IDX_W-1:0]  ptr_nxt;
  logic [SUM_W-1:0]  wait_o;

  assign commit    = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign in_tready = (state_r == S_IDLE);

  // Slice arithmetic with saturating time and sum
  always_comb begin
    add_ok  = !stepping_r && (count_r < FULL_CNT) &&
              (pri_r <= TOP_LVL) && (pri_r >= BOT_LVL);
    slice   = (res_rem_r > REM_W'(quantum_r)) ? quantum_r : res_rem_r[Q_W-1:0];
    new_rem = res_rem_r - REM_W'(slice);
    fin     = (new_rem == '0);
    el_sum  = {1'b0, elapsed_r} + (TIME_W+1)'(slice);
    el_sat  = (el_sum > (TIME_W+1)'(TIME_MAX)) ? TIME_MAX : el_sum[TIME_W-1:0];
    ts_sum  = {1'b0, tsum_r} + (SUM_W+1)'(el_sat);
    ts_sat  = (ts_sum > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : ts_sum[SUM_W-1:0];
  end

  // Result word and next state
  always_comb begin
    st_o         = ST_NONE;
    idx_o        = '0;
    slice_o      = '0;
    fin_o        = 1'b0;
    count_nxt    = count_r;
    live_cnt_nxt = live_cnt_r;
    elapsed_nxt  = elapsed_r;
    tsum_nxt     = tsum_r;
    serving_nxt  = serving_r;
    ptr_nxt      = ptr_r;
    cmd          = '0;
    cmd_idx      = res_idx_r;
    if (op_r == OP_ADD) begin
      cmd_idx = count_r[IDX_W-1:0];
      if (add_ok) begin
        st_o          = ST_ADD_OK;
        idx_o         = TIDX_W'(count_r);
        count_nxt     = count_r + 1'b1;
        live_cnt_nxt  = live_cnt_r + 1'b1;
        cmd.en        = commit;
        cmd.set_level = 1'b1;
        cmd.level     = pri_r;
        cmd.rem       = burst_r;
        cmd.live      = 1'b1;
      end else begin
        st_o = ST_ADD_REJ;
      end
    end else if (res_found_r) begin
      st_o        = ST_SLICE;
      idx_o       = TIDX_W'(res_idx_r);
      slice_o     = slice;
      fin_o       = fin;
      elapsed_nxt = el_sat;
      serving_nxt = res_lvl_r;
      ptr_nxt     = (res_idx_r == LAST_IDX) ? '0 : res_idx_r + 1'b1;
      cmd.en      = commit;
      cmd.rem     = new_rem;
      cmd.live    = !fin;
      if (fin) begin
        tsum_nxt     = ts_sat;
        live_cnt_nxt = live_cnt_r - 1'b1;
      end
    end
    wait_o = ((live_cnt_nxt == '0) && (tsum_nxt > SUM_W'(elapsed_nxt))) ?
             (tsum_nxt - SUM_W'(elapsed_nxt)) : '0;
  end

  // Sequencer, task counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      count_r     <= '0;
      live_cnt_r  <= '0;
      serving_r   <= TOP_LVL;
      ptr_r       <= '0;
      elapsed_r   <= '0;
      tsum_r      <= '0;
      stepping_r  <= 1'b0;
      quantum_r   <= QUANTUM_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        quantum_r <= cfg_wr_data;
      end
      // result register: load at commit, free once taken
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r    <= in_tuser;
            pri_r   <= in_tdata[LVL_W-1:0];
            burst_r <= in_tdata[LVL_W +: REM_W];
            cnt_r   <= '0;
            state_r <= (in_tuser == OP_STEP) ? S_SCAN : S_DONE;
          end
        end
        S_SCAN: begin
          if (cnt_r == LAST_IDX) begin
            res_found_r <= q_found;
            res_lvl_r   <= q_lvl;
            res_idx_r   <= q_idx;
            res_rem_r   <= q_rem;
            state_r     <= S_DONE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DONE: begin
          if (commit) begin
            count_r     <= count_nxt;
            live_cnt_r  <= live_cnt_nxt;
            elapsed_r   <= elapsed_nxt;
            tsum_r      <= tsum_nxt;
            serving_r   <= serving_nxt;
            ptr_r       <= ptr_nxt;
            if (op_r == OP_STEP) begin
              stepping_r <= 1'b1;
            end
            out_tuser_r <= st_o;
            out_tdata_r <= {2'b00, TCNT_W'(count_nxt), wait_o, tsum_nxt,
                            elapsed_nxt, fin_o, slice_o, idx_o};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign serving    = serving_r;
  assign ptr        = ptr_r;

  // Live tasks are a subset of accepted tasks
  a_live_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    live_cnt_r <= count_r)
    else $error("live count above accepted count");

  // A found task never sits above the serving level or below the bottom level
  a_found_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && op_r == OP_STEP && res_found_r) |->
      (res_lvl_r <= serving_r && res_lvl_r >= BOT_LVL))
    else $error("scan picked a task outside the level range");

  // Every commit loads the result register
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("result word lost at commit");

  // No task enters the table once stepping has begun
  a_no_late_add: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && op_r == OP_ADD && stepping_r) |=> $stable(count_r))
    else $error("add accepted after stepping began");

endmodule

@@ rtl/core/priority_round_robin_scheduler_top.sv @@
// Channel | Direction | Handshake         | Word
// in_     | slave     | tvalid / tready   | tdata: priority_req, burst; tuser: opcode
// out_    | master    | tvalid / tready   | tdata: result fields; tuser: status
// cfg_    | write     | wr_en             | wr_data: quantum
//
// An add is accepted and then committed. A step scans the cell chain: the
// search word walks the cell chain one cell per cycle, then the chosen entry
// is updated at commit.
// Synchronous active-low reset clears the live bits, counters and totals;
// entry level and remaining time are written on add and need no reset.
// A new word is taken while the previous result waits; the commit of that
// word stalls until the result register is free.
module priority_round_robin_scheduler_top
  import prrs_pkg::*;
#(
  parameter int MAX_TASKS    = DEF_MAX_TASKS,
  parameter int TOP_LEVEL    = DEF_TOP_LEVEL,
  parameter int BOTTOM_LEVEL = DEF_BOTTOM_LEVEL
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // priority_req[3:0], burst[15:4]
  input  logic              in_tuser,   // opcode[0]
  output logic              out_tvalid,
  input  logic              out_tready,
  // task_index[4:0], slice_length[12:5], finished[13], time_now[31:14],
  // turnaround_total[55:32], wait_total[79:56], task_count[85:80], zeros
  output logic [OUT_DW-1:0] out_tdata,
  output logic [1:0]        out_tuser,  // status[1:0]
  input  logic              cfg_wr_en,
  input  logic [Q_W-1:0]    cfg_wr_data
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  logic [LVL_W-1:0] serving;
  logic [IDX_W-1:0] ptr;
  prrs_cmd_t        cmd;
  logic [IDX_W-1:0] cmd_idx;

  // Search word taps along the chain
  logic             q_found [MAX_TASKS+1];
  logic [LVL_W-1:0] q_lvl   [MAX_TASKS+1];
  logic [IDX_W-1:0] q_idx   [MAX_TASKS+1];
  logic [REM_W-1:0] q_rem   [MAX_TASKS+1];

  // Empty search word enters the first cell
  assign q_found[0] = 1'b0;
  assign q_lvl[0]   = '0;
  assign q_idx[0]   = '0;
  assign q_rem[0]   = '0;

  for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
    prrs_cell #(
      .IDX_W (IDX_W),
      .INDEX (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .serving   (serving),
      .ptr       (ptr),
      .cmd       (cmd),
      .cmd_idx   (cmd_idx),
      .q_found_i (q_found[k]),
      .q_lvl_i   (q_lvl[k]),
      .q_idx_i   (q_idx[k]),
      .q_rem_i   (q_rem[k]),
      .q_found_o (q_found[k+1]),
      .q_lvl_o   (q_lvl[k+1]),
      .q_idx_o   (q_idx[k+1]),
      .q_rem_o   (q_rem[k+1])
    );
  end

  prrs_ctrl #(
    .MAX_TASKS    (MAX_TASKS),
    .TOP_LEVEL    (TOP_LEVEL),
    .BOTTOM_LEVEL (BOTTOM_LEVEL),
    .IDX_W        (IDX_W),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .serving     (serving),
    .ptr         (ptr),
    .cmd         (cmd),
    .cmd_idx     (cmd_idx),
    .q_found     (q_found[MAX_TASKS]),
    .q_lvl       (q_lvl[MAX_TASKS]),
    .q_idx       (q_idx[MAX_TASKS]),
    .q_rem       (q_rem[MAX_TASKS])
  );

endmodule

@@ tb/sched_ledger_pkg.sv @@
package sched_ledger_pkg;
  import prrs_pkg::*;

  localparam int NUM_SLOTS = DEF_MAX_TASKS;
  localparam int TOP_LVL   = DEF_TOP_LEVEL;
  localparam int BOT_LVL   = DEF_BOTTOM_LEVEL;

  // One result word, unpacked
  typedef struct packed {
    prrs_status_t      status;
    logic [TIDX_W-1:0] task_index;
    logic [Q_W-1:0]    slice_len;
    logic              finished;
    logic [TIME_W-1:0] time_now;
    logic [SUM_W-1:0]  turnaround;
    logic [SUM_W-1:0]  wait_sum;
    logic [TCNT_W-1:0] task_count;
  } sched_result_t;

  // Tracks the task table and scheduler position, and holds the result
  // words still owed by the block
  class schedule_ledger;
    int unsigned quantum;
    logic [LVL_W-1:0] level_of[NUM_SLOTS];
    int unsigned remaining[NUM_SLOTS];
    bit live[NUM_SLOTS];
    int unsigned task_total;
    int unsigned serve_lvl;
    int unsigned rotation;
    int unsigned elapsed;
    int unsigned tat_sum;
    bit started;
    int unsigned mismatches;
    sched_result_t owed_results[$];

    function new();
      quantum    = 32'(QUANTUM_RST);
      task_total = 0;
      serve_lvl  = TOP_LVL;
      rotation   = 0;
      elapsed    = 0;
      tat_sum    = 0;
      started    = 0;
      mismatches = 0;
      foreach (live[i]) begin
        live[i]      = 0;
        level_of[i]  = '0;
        remaining[i] = 0;
      end
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction

    // Work out the result of one accepted input word
    function void note_word(prrs_op_t op, logic [LVL_W-1:0] pri, logic [REM_W-1:0] burst);
      sched_result_t r;
      int unsigned slot;
      int unsigned first;
      int unsigned slice;
      bit found;
      bit any_live;
      r = '0;
      found = 0;
      if (op == OP_ADD) begin
        if (started || task_total >= NUM_SLOTS || pri > TOP_LVL || pri < BOT_LVL) begin
          r.status = ST_ADD_REJ;
        end else begin
          level_of[task_total]  = pri;
          remaining[task_total] = 32'(burst);
          live[task_total]      = 1;
          r.status     = ST_ADD_OK;
          r.task_index = task_total[TIDX_W-1:0];
          task_total++;
        end
      end else begin
        started = 1;
        r.status = ST_NONE;
        // search down from the level last served; rotation resumes only on that level
        for (int l = int'(serve_lvl); l >= BOT_LVL && !found; l--) begin
          first = (l == int'(serve_lvl)) ? rotation : 0;
          for (int k = 0; k < NUM_SLOTS && !found; k++) begin
            slot = (first + k) % NUM_SLOTS;
            if (live[slot] && level_of[slot] == l) begin
              found = 1;
              slice = (remaining[slot] > quantum) ? quantum : remaining[slot];
              remaining[slot] -= slice;
              elapsed += slice;
              if (elapsed > TIME_MAX) elapsed = 32'(TIME_MAX);
              if (remaining[slot] == 0) begin
                live[slot] = 0;
                r.finished = 1'b1;
                tat_sum += elapsed;
                if (tat_sum > SUM_MAX) tat_sum = 32'(SUM_MAX);
              end
              serve_lvl = l;
              rotation  = (slot + 1) % NUM_SLOTS;
              r.status     = ST_SLICE;
              r.task_index = slot[TIDX_W-1:0];
              r.slice_len  = slice[Q_W-1:0];
            end
          end
        end
      end
      any_live = 0;
      foreach (live[i]) if (live[i]) any_live = 1;
      r.time_now   = elapsed[TIME_W-1:0];
      r.turnaround = tat_sum[SUM_W-1:0];
      if (!any_live && tat_sum > elapsed) r.wait_sum = SUM_W'(tat_sum - elapsed);
      r.task_count = task_total[TCNT_W-1:0];
      owed_results.push_back(r);
    endfunction

    // Compare one result word with the oldest one owed
    function void check_word(sched_result_t got);
      sched_result_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result word with nothing outstanding, status=%0d idx=%0d",
                   got.status, got.task_index);
        return;
      end
      want = owed_results.pop_front();
      if (got.status !== want.status || got.task_index !== want.task_index ||
          got.slice_len !== want.slice_len || got.finished !== want.finished ||
          got.time_now !== want.time_now || got.turnaround !== want.turnaround ||
          got.wait_sum !== want.wait_sum || got.task_count !== want.task_count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: exp st=%0d idx=%0d sl=%0d fin=%0d t=%0d tat=%0d wt=%0d cnt=%0d",
                   want.status, want.task_index, want.slice_len, want.finished,
                   want.time_now, want.turnaround, want.wait_sum, want.task_count);
          $display("       got st=%0d idx=%0d sl=%0d fin=%0d t=%0d tat=%0d wt=%0d cnt=%0d",
                   got.status, got.task_index, got.slice_len, got.finished,
                   got.time_now, got.turnaround, got.wait_sum, got.task_count);
        end
      end
    endfunction
  endclass

endpackage

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import prrs_pkg::*;
  import sched_ledger_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_WORDS    = 145;
  localparam int HOLD_CYCLES    = 400;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;   // priority_req[3:0], burst[15:4]
  logic              in_tuser = 1'b0; // opcode[0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;       // task_index, slice, finished, time, tat, wait, count
  logic [1:0]        out_tuser;       // status[1:0]
  logic              cfg_wr_en = 1'b0;
  logic [Q_W-1:0]    cfg_wr_data = '0;

  int unsigned send_idle_pct = 14;
  int unsigned recv_idle_pct = 73;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  schedule_ledger ledger = new();
  sched_result_t seen;

  priority_round_robin_scheduler_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random backpressure, plus a long hold when asked
  always @(posedge clk) begin
    if (hold_left == 0 && hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor both channels and watch for a hung block
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        ledger.note_word(prrs_op_t'(in_tuser), in_tdata[3:0], in_tdata[15:4]);
      if (out_tvalid && out_tready) begin
        seen.status     = prrs_status_t'(out_tuser);
        seen.task_index = out_tdata[4:0];
        seen.slice_len  = out_tdata[12:5];
        seen.finished   = out_tdata[13];
        seen.time_now   = out_tdata[31:14];
        seen.turnaround = out_tdata[55:32];
        seen.wait_sum   = out_tdata[79:56];
        seen.task_count = out_tdata[85:80];
        ledger.check_word(seen);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Offer one word, with a random gap first; returns at the accepting edge
  task automatic send_word(input prrs_op_t op, input logic [LVL_W-1:0] pri,
                           input logic [REM_W-1:0] burst);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {burst, pri};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending and wait for every owed result, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [Q_W-1:0] q);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= q;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ledger.quantum = 32'(q);
  endtask

  initial begin
    int unsigned filled;
    int unsigned q;
    logic [LVL_W-1:0] pri;
    logic [REM_W-1:0] burst;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed adds at the reset quantum: out-of-range levels, zero and full bursts
    send_word(OP_ADD, 4'd0, 12'hFFF);
    send_word(OP_ADD, 4'd11, 12'h000);
    send_word(OP_ADD, 4'd15, 12'hFFF);
    send_word(OP_ADD, LVL_W'(TOP_LVL), 12'h000);
    send_word(OP_ADD, LVL_W'(BOT_LVL), 12'hFFF);
    send_word(OP_ADD, LVL_W'(TOP_LVL), 12'd25);
    send_word(OP_ADD, LVL_W'(TOP_LVL), 12'd1);
    send_word(OP_ADD, LVL_W'(BOT_LVL), 12'h000);
    send_word(OP_ADD, 4'd5, 12'd12);
    filled = 6;

    // Fill the table with random tasks, some rejected for level
    while (filled < NUM_SLOTS) begin
      if ($urandom_range(7) == 0)
        pri = ($urandom_range(1) == 0) ? 4'd0 : LVL_W'($urandom_range(15, TOP_LVL + 1));
      else
        pri = LVL_W'($urandom_range(TOP_LVL, BOT_LVL));
      burst = ($urandom_range(9) == 0) ? REM_W'($urandom_range(4095))
                                        : REM_W'($urandom_range(63));
      if (pri >= BOT_LVL && pri <= TOP_LVL) filled++;
      send_word(OP_ADD, pri, burst);
    end
    // table full, then the first step, then an add after stepping began
    send_word(OP_ADD, LVL_W'(TOP_LVL), 12'd5);
    send_word(OP_STEP, 4'd0, 12'd0);
    send_word(OP_ADD, LVL_W'(BOT_LVL), 12'd5);

    // Random phases, each at its own quantum
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: q = 1;
        1: q = 0;
        2: q = $urandom_range(15, 2);
        3: q = 85;
        5: q = 170;
        6: q = 255;
        default: q = $urandom_range(254, 1);
      endcase
      write_quantum(q[Q_W-1:0]);
      send_idle_pct = (ph < 2) ? 14 : (ph < 5) ? 73 : 0;
      recv_idle_pct = (ph < 2) ? 73 : (ph < 5) ? 14 : 0;
      // long receiver stall so the block backs up into the input
      if (ph == 3) hold_request = HOLD_CYCLES;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(3) == 0)
          send_word(OP_ADD, LVL_W'($urandom_range(15)), REM_W'($urandom_range(4095)));
        else
          send_word(OP_STEP, LVL_W'($urandom_range(15)), REM_W'($urandom_range(4095)));
      end
    end

    // Wind down
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (NUM_SLOTS + 8) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.outstanding() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
